FILE: src/wepq_pkg.sv
// shared types and constants for the windowed exit parking queue
// no dependencies; used by every module of the block by scoped names
package wepq_pkg;

    localparam int KEY_IN_W = 32;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 5;
    localparam int CAP_W    = 5;
    localparam int WIN_W    = 4;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [WIN_W-1:0] WIN_RESET = 4'd1;

    typedef enum logic {
        REG_CAPACITY    = 1'b0,
        REG_EXIT_WINDOW = 1'b1
    } reg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PARKED    = 3'd0,
        ST_FULL      = 3'd1,
        ST_DEPARTED  = 3'd2,
        ST_BLOCKED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_DEPART = 1'b1;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

FILE: src/wepq_regs.sv
// configuration registers behind the apb-style port: capacity and exit window
// depends on wepq_pkg
module wepq_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wepq_pkg::ADDR_W-1:0]   paddr,
    input  logic [wepq_pkg::DATA_W-1:0]   pwdata,
    output logic [wepq_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [wepq_pkg::CAP_W-1:0]    capacity,
    output logic [wepq_pkg::WIN_W-1:0]    exit_window
);

    logic [wepq_pkg::CAP_W-1:0] capacity_reg;
    logic [wepq_pkg::WIN_W-1:0] exit_window_reg;
    logic                       wr_en;
    wepq_pkg::reg_index_t       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = wepq_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg    <= wepq_pkg::CAP_RESET;
            exit_window_reg <= wepq_pkg::WIN_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                wepq_pkg::REG_CAPACITY:
                    capacity_reg <= pwdata[wepq_pkg::CAP_W-1:0];
                wepq_pkg::REG_EXIT_WINDOW:
                    exit_window_reg <= pwdata[wepq_pkg::WIN_W-1:0];
                default:
                    capacity_reg <= capacity_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            wepq_pkg::REG_CAPACITY:
                prdata = wepq_pkg::DATA_W'(capacity_reg);
            wepq_pkg::REG_EXIT_WINDOW:
                prdata = wepq_pkg::DATA_W'(exit_window_reg);
            default:
                prdata = '0;
        endcase
    end

    assign capacity    = capacity_reg;
    assign exit_window = exit_window_reg;

endmodule

FILE: src/wepq_ctrl.sv
// controller: sequences capture and commit of one transaction, owns both handshakes
// depends on wepq_pkg
module wepq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output wepq_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready    = (state_reg == S_IDLE);
    assign cmd.capture = in_valid && in_ready;
    assign cmd.commit  = (state_reg == S_EVAL) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (cmd.commit)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: src/wepq_dp.sv
// datapath: lane of key slots, parallel compare, priority pick, close-gap shift, result register
// depends on wepq_pkg
module wepq_dp #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wepq_pkg::cmd_t                  cmd,
    input  logic                            op,
    input  logic [wepq_pkg::KEY_IN_W-1:0]   car_key,
    input  logic [wepq_pkg::CAP_W-1:0]      capacity,
    input  logic [wepq_pkg::WIN_W-1:0]      exit_window,
    output logic [wepq_pkg::STATUS_W-1:0]   status,
    output logic [wepq_pkg::OCC_W-1:0]      occupancy,
    output logic [wepq_pkg::OCC_W-1:0]      match_position
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = (CW > wepq_pkg::CAP_W) ? CW : wepq_pkg::CAP_W;

    logic [KEY_WIDTH-1:0]          slot_reg [DEPTH];
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          op_reg;
    logic [KEY_WIDTH-1:0]          key_reg;
    logic [KEY_WIDTH-1:0]          key_in;
    logic [DEPTH-1:0]              match_reg;
    logic [DEPTH-1:0]              match_next;
    logic                          hit_found;
    logic [IW-1:0]                 hit_idx;
    logic [CW-1:0]                 hit_pos;
    logic                          lane_full;
    logic                          window_blocked;
    logic                          arrive_ok;
    logic                          depart_ok;
    wepq_pkg::status_t             status_next;
    logic [CW-1:0]                 pos_next;
    logic [wepq_pkg::STATUS_W-1:0] status_reg;
    logic [wepq_pkg::OCC_W-1:0]    occ_reg;
    logic [wepq_pkg::OCC_W-1:0]    pos_reg;

    assign key_in = KEY_WIDTH'(car_key);

    // compare against occupied slots only
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            match_next[i] = (slot_reg[i] == key_in) && (CW'(i) < count_reg);
    end

    // first match from the head
    always_comb
    begin
        hit_found = |match_reg;
        hit_idx   = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match_reg[i])
                hit_idx = IW'(i);
        end
    end

    assign hit_pos        = CW'(hit_idx) + CW'(1);
    assign lane_full      = (CMPW'(count_reg) >= CMPW'(capacity))
                            || (count_reg == CW'(DEPTH));
    assign window_blocked = CMPW'(hit_pos) > CMPW'(exit_window);
    assign arrive_ok      = (op_reg == wepq_pkg::OP_ARRIVE) && !lane_full;
    assign depart_ok      = (op_reg == wepq_pkg::OP_DEPART) && hit_found
                            && !window_blocked;

    always_comb
    begin
        count_next  = count_reg;
        pos_next    = '0;
        status_next = wepq_pkg::ST_NOT_FOUND;
        priority if (op_reg == wepq_pkg::OP_ARRIVE)
        begin
            if (lane_full)
                status_next = wepq_pkg::ST_FULL;
            else
            begin
                status_next = wepq_pkg::ST_PARKED;
                count_next  = count_reg + CW'(1);
                pos_next    = count_reg + CW'(1);
            end
        end
        else if (hit_found)
        begin
            pos_next = hit_pos;
            if (window_blocked)
                status_next = wepq_pkg::ST_BLOCKED;
            else
            begin
                status_next = wepq_pkg::ST_DEPARTED;
                count_next  = count_reg - CW'(1);
            end
        end
        else
            status_next = wepq_pkg::ST_NOT_FOUND;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.commit)
            count_reg <= count_next;
    end

    // lane slots: append at the tail or close the gap toward the head
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (depart_ok && (i < DEPTH - 1) && (IW'(i) >= hit_idx))
                    slot_reg[i] <= slot_reg[(i + 1) % DEPTH];
                else if (arrive_ok && (count_reg == CW'(i)))
                    slot_reg[i] <= key_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            key_reg   <= key_in;
            match_reg <= match_next;
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            occ_reg    <= wepq_pkg::OCC_W'(count_next);
            pos_reg    <= wepq_pkg::OCC_W'(pos_next);
        end
    end

    assign status         = status_reg;
    assign occupancy      = occ_reg;
    assign match_position = pos_reg;

endmodule

FILE: src/windowed_exit_parking_queue.sv
// top level of the windowed exit parking queue: registers, controller and datapath
// depends on wepq_pkg, wepq_regs, wepq_ctrl, wepq_dp
//
//  channel   handshake             payload
//  input     in_valid / in_ready   op, car_key
//  output    out_valid / out_ready status, occupancy, match_position
//  config    apb psel/penable      paddr, pwdata, prdata (capacity at 0, exit_window at 4)
//
// a transaction is captured and then committed: the capture registers the compare of every slot against the key,
// the commit picks the first match, updates the lane and loads the result register
// one transaction is in flight at a time; in_ready rises again after the commit cycle
// the commit waits while a previous result is still held on the output
// rst_n clears the occupancy, the handshake state and the registers; no clearing pass
module windowed_exit_parking_queue #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic [wepq_pkg::KEY_IN_W-1:0]   car_key,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [wepq_pkg::STATUS_W-1:0]   status,
    output logic [wepq_pkg::OCC_W-1:0]      occupancy,
    output logic [wepq_pkg::OCC_W-1:0]      match_position,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wepq_pkg::ADDR_W-1:0]     paddr,
    input  logic [wepq_pkg::DATA_W-1:0]     pwdata,
    output logic [wepq_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    wepq_pkg::cmd_t             cmd;
    logic [wepq_pkg::CAP_W-1:0] capacity;
    logic [wepq_pkg::WIN_W-1:0] exit_window;

    wepq_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .capacity    (capacity),
        .exit_window (exit_window)
    );

    wepq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    wepq_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .op             (op),
        .car_key        (car_key),
        .capacity       (capacity),
        .exit_window    (exit_window),
        .status         (status),
        .occupancy      (occupancy),
        .match_position (match_position)
    );

endmodule

FILE: src/wepq_checker.sv
// port-level checks for the windowed exit parking queue, bound to the top level
// depends on wepq_pkg and windowed_exit_parking_queue
module wepq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [wepq_pkg::STATUS_W-1:0]   status,
    input logic [wepq_pkg::OCC_W-1:0]      occupancy,
    input logic [wepq_pkg::OCC_W-1:0]      match_position
);

    // one transaction at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction accepted while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
        && $stable(occupancy) && $stable(match_position))
        else $error("stalled result changed");

    a_parked_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == wepq_pkg::ST_PARKED) |-> match_position == occupancy
        && match_position != '0)
        else $error("parked car not at the tail");

    a_no_match_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == wepq_pkg::ST_FULL) || (status == wepq_pkg::ST_NOT_FOUND))
        |-> match_position == '0)
        else $error("position reported without a match");

endmodule

bind windowed_exit_parking_queue wepq_checker u_wepq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .occupancy      (occupancy),
    .match_position (match_position)
);
